// ----- sv/bthd_pkg.sv -----
// ----------------------------------------------------------------------------
// bthd_pkg: shared types and constants
// Request and response structs, parse phases, status and object codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bthd_pkg;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_TOO_SHORT   = 3'd1,
      ST_BAD_VERSION = 3'd2,
      ST_ENCRYPTED   = 3'd3,
      ST_TRUNCATED   = 3'd4,
      ST_UNKNOWN     = 3'd5,
      ST_MISSING     = 3'd6
   } status_type;

   typedef enum logic [4:0] {
      PH_HEADER = 5'b00001,
      PH_OBJID  = 5'b00010,
      PH_FIRST  = 5'b00100,
      PH_SECOND = 5'b01000,
      PH_ERROR  = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      OBJ_PACKET_ID   = 2'd0,
      OBJ_BATTERY     = 2'd1,
      OBJ_TEMPERATURE = 2'd2,
      OBJ_HUMIDITY    = 2'd3
   } obj_type;

   localparam logic [2:0]  HDR_VERSION    = 3'd2;
   localparam logic [15:0] HUMIDITY_LIMIT = 16'd10000;

   // presence flag bit positions
   localparam int FLAG_TEMP = 0;
   localparam int FLAG_HUM  = 1;
   localparam int FLAG_BAT  = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       empty_packet;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [15:0] temperature_centi;
      logic [15:0]        humidity_centi;
      logic [7:0]         battery_percent;
      logic               temperature_seen;
      logic               humidity_seen;
      logic               battery_seen;
   } rsp_type;

endpackage

`default_nettype wire

// ----- sv/bthd_parser.sv -----
// ----------------------------------------------------------------------------
// bthd_parser: payload parse state and result formation
// Walks header and objects one byte per request, builds the response.
// ----------------------------------------------------------------------------
`default_nettype none

module bthd_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             go,
   input  wire bthd_pkg::req_type req,
   output bthd_pkg::rsp_type     rsp
);

   bthd_pkg::phase_type  phase_ff, phase_in, phase_nx;
   bthd_pkg::obj_type    obj_ff, obj_in, obj_nx;
   bthd_pkg::status_type err_ff, err_in, err_nx;
   logic [7:0]           low_ff, low_in, low_nx;
   logic [15:0]          temp_ff, temp_in, temp_nx;
   logic [15:0]          hum_ff, hum_in, hum_nx;
   logic [7:0]           bat_ff, bat_in, bat_nx;
   logic [2:0]           flags_ff, flags_in, flags_nx;
   bthd_pkg::status_type status;

   // state after taking the current byte
   always_comb begin
      phase_nx = phase_ff;
      obj_nx   = obj_ff;
      err_nx   = err_ff;
      low_nx   = low_ff;
      temp_nx  = temp_ff;
      hum_nx   = hum_ff;
      bat_nx   = bat_ff;
      flags_nx = flags_ff;
      if (!req.empty_packet) begin
         unique case (phase_ff)
            bthd_pkg::PH_HEADER: begin
               if (req.data_byte[7:5] != bthd_pkg::HDR_VERSION) begin
                  phase_nx = bthd_pkg::PH_ERROR;
                  err_nx   = bthd_pkg::ST_BAD_VERSION;
               end else if (req.data_byte[0]) begin
                  phase_nx = bthd_pkg::PH_ERROR;
                  err_nx   = bthd_pkg::ST_ENCRYPTED;
               end else begin
                  phase_nx = bthd_pkg::PH_OBJID;
               end
            end
            bthd_pkg::PH_OBJID: begin
               if (req.data_byte[7:2] == 6'd0) begin
                  obj_nx   = bthd_pkg::obj_type'(req.data_byte[1:0]);
                  phase_nx = bthd_pkg::PH_FIRST;
               end else begin
                  phase_nx = bthd_pkg::PH_ERROR;
                  err_nx   = bthd_pkg::ST_UNKNOWN;
               end
            end
            bthd_pkg::PH_FIRST: begin
               unique case (obj_ff)
                  bthd_pkg::OBJ_PACKET_ID: begin
                     phase_nx = bthd_pkg::PH_OBJID;
                  end
                  bthd_pkg::OBJ_BATTERY: begin
                     bat_nx                     = req.data_byte;
                     flags_nx[bthd_pkg::FLAG_BAT] = 1'b1;
                     phase_nx                   = bthd_pkg::PH_OBJID;
                  end
                  default: begin
                     low_nx   = req.data_byte;
                     phase_nx = bthd_pkg::PH_SECOND;
                  end
               endcase
            end
            bthd_pkg::PH_SECOND: begin
               if (obj_ff == bthd_pkg::OBJ_TEMPERATURE) begin
                  temp_nx                       = {req.data_byte, low_ff};
                  flags_nx[bthd_pkg::FLAG_TEMP] = 1'b1;
               end else begin
                  hum_nx                       = {req.data_byte, low_ff};
                  flags_nx[bthd_pkg::FLAG_HUM] = 1'b1;
               end
               phase_nx = bthd_pkg::PH_OBJID;
            end
            default: begin
               // error phase: bytes are dropped
            end
         endcase
      end
   end

   always_comb begin
      unique case (phase_nx)
         bthd_pkg::PH_HEADER: status = bthd_pkg::ST_TOO_SHORT;
         bthd_pkg::PH_FIRST,
         bthd_pkg::PH_SECOND: status = bthd_pkg::ST_TRUNCATED;
         bthd_pkg::PH_OBJID: begin
            if (!flags_nx[bthd_pkg::FLAG_TEMP] || !flags_nx[bthd_pkg::FLAG_HUM] ||
                (hum_nx > bthd_pkg::HUMIDITY_LIMIT)) begin
               status = bthd_pkg::ST_MISSING;
            end else begin
               status = bthd_pkg::ST_OK;
            end
         end
         default: status = err_nx;
      endcase
   end

   always_comb begin
      rsp.status            = status;
      rsp.temperature_centi = temp_nx;
      rsp.humidity_centi    = hum_nx;
      rsp.battery_percent   = bat_nx;
      rsp.temperature_seen  = flags_nx[bthd_pkg::FLAG_TEMP];
      rsp.humidity_seen     = flags_nx[bthd_pkg::FLAG_HUM];
      rsp.battery_seen      = flags_nx[bthd_pkg::FLAG_BAT];
   end

   // the last request of a packet returns the parser to its start state
   always_comb begin
      if (req.last_byte) begin
         phase_in = bthd_pkg::PH_HEADER;
         obj_in   = bthd_pkg::OBJ_PACKET_ID;
         err_in   = bthd_pkg::ST_OK;
         low_in   = 8'd0;
         temp_in  = 16'd0;
         hum_in   = 16'd0;
         bat_in   = 8'd0;
         flags_in = 3'd0;
      end else begin
         phase_in = phase_nx;
         obj_in   = obj_nx;
         err_in   = err_nx;
         low_in   = low_nx;
         temp_in  = temp_nx;
         hum_in   = hum_nx;
         bat_in   = bat_nx;
         flags_in = flags_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bthd_pkg::PH_HEADER;
         obj_ff   <= bthd_pkg::OBJ_PACKET_ID;
         err_ff   <= bthd_pkg::ST_OK;
         low_ff   <= 8'd0;
         temp_ff  <= 16'd0;
         hum_ff   <= 16'd0;
         bat_ff   <= 8'd0;
         flags_ff <= 3'd0;
      end else if (go) begin
         phase_ff <= phase_in;
         obj_ff   <= obj_in;
         err_ff   <= err_in;
         low_ff   <= low_in;
         temp_ff  <= temp_in;
         hum_ff   <= hum_in;
         bat_ff   <= bat_in;
         flags_ff <= flags_in;
      end
   end

   a_err_code: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bthd_pkg::PH_ERROR) |->
         (err_ff == bthd_pkg::ST_BAD_VERSION || err_ff == bthd_pkg::ST_ENCRYPTED ||
          err_ff == bthd_pkg::ST_UNKNOWN))
      else $error("error phase without an error code");

   a_header_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == bthd_pkg::PH_HEADER) |-> (flags_ff == 3'd0))
      else $error("presence flags set before a header");

endmodule

`default_nettype wire

// ----- sv/bthome_v2_climate_decoder.sv -----
// ----------------------------------------------------------------------------
// bthome_v2_climate_decoder: BTHome v2 climate payload decoder
// Input register, single-pass parser and registered response.
// ----------------------------------------------------------------------------
// One payload byte is taken per request, and a request can be accepted every
// clock cycle. Each request sits in an input register while the parser
// updates its state; a request marked last produces one response in the
// output register, loaded from the parser as the input register is freed.
// The throughput is set by the single parse stage; the input only stalls when
// a last request finds the response register still full and not being taken.
`default_nettype none

module bthome_v2_climate_decoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire bthd_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      bthd_pkg::rsp_type rsp_data
);

   logic              in_vld_ff, in_vld_in;
   bthd_pkg::req_type in_req_ff;
   logic              out_vld_ff, out_vld_in;
   bthd_pkg::rsp_type out_rsp_ff;
   bthd_pkg::rsp_type parse_rsp;
   logic              proc_go;
   logic              out_load;

   // a non-last request never needs the response register
   assign proc_go   = in_vld_ff && (!in_req_ff.last_byte || !out_vld_ff || rsp_ready);
   assign out_load  = proc_go && in_req_ff.last_byte;
   assign req_ready = !in_vld_ff || proc_go;

   assign in_vld_in  = (req_valid && req_ready) || (in_vld_ff && !proc_go);
   assign out_vld_in = out_load || (out_vld_ff && !rsp_ready);

   bthd_parser u_parser (
      .clock (clock),
      .reset (reset),
      .go    (proc_go),
      .req   (in_req_ff),
      .rsp   (parse_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_req_ff <= req_data;
      end
      if (out_load) begin
         out_rsp_ff <= parse_rsp;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_rsp_ff;

   a_last_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      out_load |=> out_vld_ff)
      else $error("last request did not produce a response");

   a_ok_has_climate: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_rsp_ff.status == bthd_pkg::ST_OK) |->
         (out_rsp_ff.temperature_seen && out_rsp_ff.humidity_seen &&
          out_rsp_ff.humidity_centi <= bthd_pkg::HUMIDITY_LIMIT))
      else $error("ok status without valid climate data");

   a_short_is_empty: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_rsp_ff.status == bthd_pkg::ST_TOO_SHORT) |->
         (!out_rsp_ff.temperature_seen && !out_rsp_ff.humidity_seen &&
          !out_rsp_ff.battery_seen))
      else $error("too_short response carries decoded fields");

endmodule

`default_nettype wire

// ----- tb/bthd_reading_checker.sv -----
// ----------------------------------------------------------------------------
// bthd_reading_checker: climate reading predictor and response checker
// Watches both channels of the decoder, decodes every accepted request with
// its own parser and compares each response against the oldest prediction.
// ----------------------------------------------------------------------------

module bthd_reading_checker
   import bthd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      failures,
   output int      open_results
);

   // parser state
   phase_type   stage;
   obj_type     obj_id;
   logic [7:0]  low_byte;
   status_type  first_error;
   logic [15:0] temp_c;
   logic [15:0] hum_c;
   logic [7:0]  batt;
   logic [2:0]  seen;

   rsp_type     expected_readings[$];
   rsp_type     reading;
   rsp_type     want;
   int          fail_total = 0;

   function automatic void clear_decoder();
      stage       = PH_HEADER;
      obj_id      = OBJ_PACKET_ID;
      low_byte    = '0;
      first_error = ST_OK;
      temp_c      = '0;
      hum_c       = '0;
      batt        = '0;
      seen        = '0;
   endfunction

   function automatic void decode_byte(input logic [7:0] b);
      case (stage)
         PH_HEADER: begin
            // version is checked ahead of the encryption bit
            if (b[7:5] != HDR_VERSION) begin
               first_error = ST_BAD_VERSION;
               stage       = PH_ERROR;
            end else if (b[0]) begin
               first_error = ST_ENCRYPTED;
               stage       = PH_ERROR;
            end else begin
               stage = PH_OBJID;
            end
         end
         PH_OBJID: begin
            if (b <= {6'd0, OBJ_HUMIDITY}) begin
               obj_id = obj_type'(b[1:0]);
               stage  = PH_FIRST;
            end else begin
               first_error = ST_UNKNOWN;
               stage       = PH_ERROR;
            end
         end
         PH_FIRST: begin
            case (obj_id)
               OBJ_PACKET_ID: stage = PH_OBJID;
               OBJ_BATTERY: begin
                  batt           = b;
                  seen[FLAG_BAT] = 1'b1;
                  stage          = PH_OBJID;
               end
               default: begin
                  low_byte = b;
                  stage    = PH_SECOND;
               end
            endcase
         end
         PH_SECOND: begin
            if (obj_id == OBJ_TEMPERATURE) begin
               temp_c          = {b, low_byte};
               seen[FLAG_TEMP] = 1'b1;
            end else begin
               hum_c          = {b, low_byte};
               seen[FLAG_HUM] = 1'b1;
            end
            stage = PH_OBJID;
         end
         default: ;
      endcase
   endfunction

   function automatic status_type closing_status();
      case (stage)
         PH_HEADER:           return ST_TOO_SHORT;
         PH_FIRST, PH_SECOND: return ST_TRUNCATED;
         PH_OBJID: begin
            if (!seen[FLAG_TEMP] || !seen[FLAG_HUM] || hum_c > HUMIDITY_LIMIT)
               return ST_MISSING;
            return ST_OK;
         end
         default:             return first_error;
      endcase
   endfunction

   // returns 1 when the request closes a payload
   function automatic bit apply_request(input req_type r, output rsp_type res);
      res = '0;
      if (!r.empty_packet)
         decode_byte(r.data_byte);
      if (!r.last_byte)
         return 1'b0;
      res.status            = closing_status();
      res.temperature_centi = temp_c;
      res.humidity_centi    = hum_c;
      res.battery_percent   = batt;
      res.temperature_seen  = seen[FLAG_TEMP];
      res.humidity_seen     = seen[FLAG_HUM];
      res.battery_seen      = seen[FLAG_BAT];
      clear_decoder();
      return 1'b1;
   endfunction

   function automatic void note_failure(input string msg);
      if (fail_total < 10)
         $display("%0t: %s", $realtime, msg);
      fail_total++;
   endfunction

   function automatic string show(input rsp_type r);
      return $sformatf("status=%0d temp=%0d hum=%0d batt=%0d flags(t,h,b)=%b%b%b",
                       r.status, r.temperature_centi, r.humidity_centi,
                       r.battery_percent, r.temperature_seen, r.humidity_seen,
                       r.battery_seen);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_decoder();
         expected_readings.delete();
      end else begin
         if ($isunknown(req_ready) || $isunknown(rsp_valid))
            note_failure("handshake output is unknown");
         if (rsp_valid === 1'b1 && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               note_failure({"response with none pending: ", show(rsp_data)});
            end else begin
               want = expected_readings.pop_front();
               if (rsp_data.status !== want.status
                   || rsp_data.temperature_centi !== want.temperature_centi
                   || rsp_data.humidity_centi !== want.humidity_centi
                   || rsp_data.battery_percent !== want.battery_percent
                   || rsp_data.temperature_seen !== want.temperature_seen
                   || rsp_data.humidity_seen !== want.humidity_seen
                   || rsp_data.battery_seen !== want.battery_seen)
                  note_failure({"mismatch: expected ", show(want),
                                " got ", show(rsp_data)});
            end
         end
         if (req_valid && req_ready === 1'b1) begin
            if (apply_request(req_data, reading))
               expected_readings.push_back(reading);
         end
      end
      failures     <= fail_total;
      open_results <= expected_readings.size();
   end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: BTHome v2 climate decoder testbench
// Drives directed and random payloads byte by byte with random idling on both
// channels, a long response hold-off and drain pauses; checking is done by
// bthd_reading_checker.
// ----------------------------------------------------------------------------

module tb;
   import bthd_pkg::*;

   typedef logic [7:0] byte_list_type[$];

   localparam logic [7:0] HDR_PLAIN   = {HDR_VERSION, 5'b00000};
   localparam logic [7:0] ENCRYPT_BIT = 8'h01;
   localparam logic [7:0] ID_PACKET   = {6'd0, OBJ_PACKET_ID};
   localparam logic [7:0] ID_BATTERY  = {6'd0, OBJ_BATTERY};
   localparam logic [7:0] ID_TEMP     = {6'd0, OBJ_TEMPERATURE};
   localparam logic [7:0] ID_HUM      = {6'd0, OBJ_HUMIDITY};
   localparam logic [7:0] ID_UNKNOWN  = ID_HUM + 8'd1;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   int failures;
   int open_results;
   int req_gap_max = 0;
   int rsp_gap_max = 0;
   int rsp_hold    = 0;
   int items_sent  = 0;

   bthome_v2_climate_decoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   bthd_reading_checker checker_i (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .failures     (failures),
      .open_results (open_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("[bthome_v2_climate_decoder] ERROR");
      $finish;
   end

   // response side: random stalls, plus a long hold-off when asked
   initial begin
      int gap;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (rsp_hold > 0) begin
            gap      = rsp_hold;
            rsp_hold = 0;
         end else begin
            gap = $urandom_range(0, rsp_gap_max);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         @(negedge clock);
      end
   end

   task automatic send_req(input req_type r);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // one payload; ends on an empty last request when asked or when it has no bytes
   task automatic send_packet(input byte_list_type bytes, input bit end_empty,
                              input int stray_pct);
      req_type r;
      int      n;
      n = bytes.size();
      foreach (bytes[i]) begin
         if ($urandom_range(1, 100) <= stray_pct) begin
            r = '{data_byte: 8'($urandom), last_byte: 1'b0, empty_packet: 1'b1};
            send_req(r);
         end
         r = '{data_byte: bytes[i], last_byte: (i == n - 1) && !end_empty,
               empty_packet: 1'b0};
         send_req(r);
         items_sent++;
      end
      if (end_empty || n == 0) begin
         r = '{data_byte: 8'($urandom), last_byte: 1'b1, empty_packet: 1'b1};
         send_req(r);
         items_sent++;
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (open_results != 0) @(posedge clock);
   endtask

   function automatic byte_list_type object_bytes(input obj_type id);
      byte_list_type q;
      logic [15:0]   v;
      v = 16'($urandom);
      q.push_back({6'd0, id});
      case (id)
         OBJ_TEMPERATURE: begin
            case ($urandom_range(0, 3))
               0:       v = 16'h8000;
               1:       v = 16'h7FFF;
               default: ;
            endcase
         end
         OBJ_HUMIDITY: begin
            case ($urandom_range(0, 5))
               0:       v = HUMIDITY_LIMIT;
               1:       v = HUMIDITY_LIMIT + 16'd1;
               2:       v = 16'hFFFF;
               3:       ;
               default: v = 16'($urandom_range(0, HUMIDITY_LIMIT));
            endcase
         end
         default: ;
      endcase
      q.push_back(v[7:0]);
      if (id == OBJ_TEMPERATURE || id == OBJ_HUMIDITY)
         q.push_back(v[15:8]);
      return q;
   endfunction

   // valid header, temperature and humidity in random order plus a few extras, optionally an unknown object id
   function automatic byte_list_type make_climate(input bit with_unknown);
      byte_list_type q;
      obj_type       ids[$];
      int            spot;
      logic [7:0]    stray;
      q.push_back({HDR_VERSION, 4'($urandom), 1'b0});
      ids.push_back(OBJ_TEMPERATURE);
      ids.insert($urandom_range(0, 1), OBJ_HUMIDITY);
      repeat ($urandom_range(0, 3))
         ids.insert($urandom_range(0, ids.size()), obj_type'($urandom_range(0, 3)));
      // now and then drop one object, which may leave climate data missing
      if ($urandom_range(0, 9) == 0)
         ids.delete($urandom_range(0, ids.size() - 1));
      spot  = with_unknown ? $urandom_range(0, ids.size()) : -1;
      stray = ID_HUM + 8'($urandom_range(1, 252));
      foreach (ids[i]) begin
         if (i == spot)
            q.push_back(stray);
         q = {q, object_bytes(ids[i])};
      end
      if (spot == ids.size())
         q.push_back(stray);
      return q;
   endfunction

   initial begin
      byte_list_type pkt;
      req_type       r;
      int            kind;
      int            target;
      int            seg;
      int            drain;
      bit            end_empty;

      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed payloads
      req_gap_max = 3;
      rsp_gap_max = 3;
      pkt = {};
      send_packet(pkt, 1'b0, 0);
      r = '{data_byte: 8'h5A, last_byte: 1'b0, empty_packet: 1'b1};
      send_req(r);
      send_packet('{HDR_PLAIN, ID_TEMP, 8'h00, 8'h80, ID_HUM, 8'h10, 8'h27,
                    ID_BATTERY, 8'hFF, ID_PACKET, 8'hAA}, 1'b1, 0);
      send_packet('{HDR_PLAIN | 8'h1E, ID_HUM, 8'h11, 8'h27}, 1'b0, 0);
      send_packet('{8'hFF}, 1'b0, 0);
      send_packet('{HDR_PLAIN | ENCRYPT_BIT}, 1'b0, 0);
      send_packet('{HDR_PLAIN, ID_BATTERY, 8'h00, ID_UNKNOWN, ID_TEMP}, 1'b0, 0);
      send_packet('{HDR_PLAIN, ID_TEMP, 8'h34}, 1'b0, 0);
      drain_results();

      // response side holds off while requests keep coming, then a full drain
      req_gap_max = 0;
      rsp_gap_max = 0;
      rsp_hold    = 300;
      repeat (20) send_packet(make_climate(1'b0), 1'b0, 0);
      drain_results();

      target = items_sent + 300;
      seg    = 0;
      while (items_sent < target) begin
         case (seg % 4)
            0:       begin req_gap_max = 0;  rsp_gap_max = 0;  end
            1:       begin req_gap_max = 18; rsp_gap_max = 18; end
            2:       begin req_gap_max = 2;  rsp_gap_max = 18; end
            default: begin req_gap_max = 18; rsp_gap_max = 3;  end
         endcase
         repeat (6) begin
            kind      = $urandom_range(0, 9);
            end_empty = ($urandom_range(0, 4) == 0);
            case (kind)
               0, 1, 2, 3, 4, 5: pkt = make_climate(1'b0);
               6: begin
                  pkt = make_climate(1'b0);
                  repeat ($urandom_range(1, pkt.size() - 1)) void'(pkt.pop_back());
               end
               7: begin
                  pkt = make_climate(1'b0);
                  pkt[0] = $urandom_range(0, 1) ? 8'($urandom)
                                                : {HDR_VERSION, 4'($urandom), 1'b1};
               end
               8: pkt = make_climate(1'b1);
               default: begin
                  pkt = {};
                  repeat ($urandom_range(0, 5)) pkt.push_back(8'($urandom));
               end
            endcase
            send_packet(pkt, end_empty, 10);
         end
         if (seg % 3 == 2)
            drain_results();
         seg++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      drain = 0;
      while (open_results != 0 && drain < 20000) begin
         @(posedge clock);
         drain++;
      end
      repeat (20) @(posedge clock);
      if (failures == 0 && open_results == 0)
         $display("[bthome_v2_climate_decoder] OK");
      else
         $display("[bthome_v2_climate_decoder] ERROR");
      $finish;
   end

endmodule

// ----- bthome_v2_climate_decoder.f -----
sv/bthd_pkg.sv
sv/bthd_parser.sv
sv/bthome_v2_climate_decoder.sv
tb/bthd_reading_checker.sv
tb/tb.sv
